// File: sv/smm_pkg.sv
// Shared types, constants and codes for the single precision matrix multiply core.
// No dependencies; every other file imports this package.
package smm_pkg;

    localparam int MAX_ROWS  = 64;
    localparam int MAX_COLS  = 64;
    localparam int MAX_INNER = 64;

    localparam int ROW_W  = 6;
    localparam int COL_W  = 6;
    localparam int DIM_W  = 7;
    localparam int WORD_W = 32;

    localparam int A_DEPTH  = MAX_ROWS * MAX_INNER;
    localparam int B_DEPTH  = MAX_INNER * MAX_COLS;
    localparam int A_ADDR_W = $clog2(A_DEPTH);
    localparam int B_ADDR_W = $clog2(B_DEPTH);

    localparam logic [DIM_W-1:0] ROWS_SAT  = DIM_W'(MAX_ROWS);
    localparam logic [DIM_W-1:0] COLS_SAT  = DIM_W'(MAX_COLS);
    localparam logic [DIM_W-1:0] INNER_SAT = DIM_W'(MAX_INNER);

    // command codes of an input transaction
    localparam logic [1:0] CMD_WR_A = 2'd0;
    localparam logic [1:0] CMD_WR_B = 2'd1;
    localparam logic [1:0] CMD_ROW  = 2'd2;

    // register indexes on the configuration port
    localparam logic [1:0] REG_ROWS  = 2'd0;
    localparam logic [1:0] REG_COLS  = 2'd1;
    localparam logic [1:0] REG_INNER = 2'd2;

    // floating point unit operations
    localparam logic FOP_MUL = 1'b0;
    localparam logic FOP_ADD = 1'b1;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [WORD_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [ROW_W-1:0]  out_row;
        logic [COL_W-1:0]  out_col;
        logic [WORD_W-1:0] out_value;
        logic              last;
    } t_out_item;

    typedef struct packed {
        logic              op;
        logic [WORD_W-1:0] opa;
        logic [WORD_W-1:0] opb;
    } t_fpu_req;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] value;
    } t_fpu_rsp;

    typedef struct packed {
        logic                wr_a;
        logic                wr_b;
        logic [A_ADDR_W-1:0] wr_addr_a;
        logic [B_ADDR_W-1:0] wr_addr_b;
        logic [WORD_W-1:0]   wr_data;
        logic [A_ADDR_W-1:0] rd_addr_a;
        logic [B_ADDR_W-1:0] rd_addr_b;
    } t_store_req;

endpackage

// File: sv/smm_store.sv
// Element stores for matrices A and B: one write port, one registered read port each.
// Depends on smm_pkg.
module smm_store import smm_pkg::*; (
    input  logic              i_clk,
    input  t_store_req        i_req,
    output logic [WORD_W-1:0] o_rd_a,
    output logic [WORD_W-1:0] o_rd_b
);

    logic [WORD_W-1:0] r_mem_a [A_DEPTH];
    logic [WORD_W-1:0] r_mem_b [B_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_req.wr_a) begin
            r_mem_a[i_req.wr_addr_a] <= i_req.wr_data;
        end
        o_rd_a <= r_mem_a[i_req.rd_addr_a];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_b) begin
            r_mem_b[i_req.wr_addr_b] <= i_req.wr_data;
        end
        o_rd_b <= r_mem_b[i_req.rd_addr_b];
    end

endmodule

// File: sv/smm_fpu.sv
// Multi-cycle binary32 multiply / add unit with a shared normalize and round path.
// Depends on smm_pkg.
module smm_fpu import smm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_fpu_req i_req,
    output t_fpu_rsp o_rsp
);

    localparam logic [2:0] F_IDLE   = 3'd0;
    localparam logic [2:0] F_PREP   = 3'd1;
    localparam logic [2:0] F_ALIGN  = 3'd2;
    localparam logic [2:0] F_NORM   = 3'd3;
    localparam logic [2:0] F_DENORM = 3'd4;
    localparam logic [2:0] F_ROUND  = 3'd5;

    localparam logic [31:0] DEF_NAN  = 32'h7FC0_0000;
    localparam logic [31:0] QUIET    = 32'h0040_0000;
    localparam logic [30:0] INF_MAG  = 31'h7F80_0000;

    function automatic logic f_nan(input logic [31:0] x);
        return x[30:0] > INF_MAG;
    endfunction

    function automatic logic f_inf(input logic [31:0] x);
        return x[30:0] == INF_MAG;
    endfunction

    function automatic logic f_zero(input logic [31:0] x);
        return x[30:0] == 31'd0;
    endfunction

    logic [2:0]         r_state;
    logic               r_op;
    logic [31:0]        r_a;
    logic [31:0]        r_b;
    logic               r_sign;
    logic               r_sub;
    logic signed [10:0] r_exp;
    logic [47:0]        r_sig;
    logic [23:0]        r_big;
    logic [23:0]        r_small;
    logic [7:0]         r_d;
    logic               r_done;
    logic [31:0]        r_value;

    // unpacked operands
    logic [7:0]  ea8, eb8;
    logic [23:0] ma, mb;
    logic        a_big;

    assign ea8   = (r_a[30:23] == 8'd0) ? 8'd1 : r_a[30:23];
    assign eb8   = (r_b[30:23] == 8'd0) ? 8'd1 : r_b[30:23];
    assign ma    = {(r_a[30:23] != 8'd0), r_a[22:0]};
    assign mb    = {(r_b[30:23] != 8'd0), r_b[22:0]};
    assign a_big = r_a[30:0] >= r_b[30:0];

    // special operands
    logic        spc_hit;
    logic [31:0] spc_val;

    always_comb begin
        spc_hit = 1'b1;
        spc_val = 32'd0;
        if (r_op == FOP_MUL) begin
            priority if (f_nan(r_a)) begin
                spc_val = r_a | QUIET;
            end else if (f_nan(r_b)) begin
                spc_val = r_b | QUIET;
            end else if (f_inf(r_a) || f_inf(r_b)) begin
                spc_val = (f_zero(r_a) || f_zero(r_b)) ? DEF_NAN
                                                       : {r_a[31] ^ r_b[31], INF_MAG};
            end else if (f_zero(r_a) || f_zero(r_b)) begin
                spc_val = {r_a[31] ^ r_b[31], 31'd0};
            end else begin
                spc_hit = 1'b0;
            end
        end else begin
            priority if (f_nan(r_a)) begin
                spc_val = r_a | QUIET;
            end else if (f_nan(r_b)) begin
                spc_val = r_b | QUIET;
            end else if (f_inf(r_a)) begin
                spc_val = (f_inf(r_b) && (r_a[31] != r_b[31])) ? DEF_NAN : r_a;
            end else if (f_inf(r_b)) begin
                spc_val = r_b;
            end else if (f_zero(r_a) && f_zero(r_b)) begin
                spc_val = {r_a[31] & r_b[31], 31'd0};
            end else if (f_zero(r_a)) begin
                spc_val = r_b;
            end else if (f_zero(r_b)) begin
                spc_val = r_a;
            end else if ((r_a[30:0] == r_b[30:0]) && (r_a[31] != r_b[31])) begin
                spc_val = 32'd0;
            end else begin
                spc_hit = 1'b0;
            end
        end
    end

    // alignment and add of significands
    logic [47:0] big48, sm48, sm_shift;
    logic        sm_sticky;
    logic [48:0] sum49;

    always_comb begin
        big48 = {r_big, 24'd0};
        sm48  = {r_small, 24'd0};
        if (r_d >= 8'd48) begin
            sm_shift = 48'd1;
        end else begin
            sm_sticky = |(sm48 & ((48'd1 << r_d[5:0]) - 48'd1));
            sm_shift  = (sm48 >> r_d[5:0]) | {47'd0, sm_sticky};
        end
        sm_sticky = 1'b0;
        sum49 = r_sub ? ({1'b0, big48} - {1'b0, sm_shift})
                      : ({1'b0, big48} + {1'b0, sm_shift});
    end

    // right shift into the subnormal range
    logic signed [10:0] dn_sh;
    logic [47:0]        dn_sig;

    always_comb begin
        dn_sh = 11'sd1 - r_exp;
        if (dn_sh >= 11'sd48) begin
            dn_sig = 48'd1;
        end else begin
            dn_sig = (r_sig >> dn_sh[5:0])
                   | {47'd0, |(r_sig & ((48'd1 << dn_sh[5:0]) - 48'd1))};
        end
    end

    // round to nearest even and pack
    logic [23:0] rnd_m;
    logic        rnd_up;
    logic [24:0] rnd_m25;
    logic [7:0]  rnd_e;
    logic [31:0] rnd_mag;

    always_comb begin
        rnd_m   = r_sig[47:24];
        rnd_up  = r_sig[23] && ((|r_sig[22:0]) || rnd_m[0]);
        rnd_m25 = {1'b0, rnd_m} + {24'd0, rnd_up};
        rnd_e   = 8'(r_exp - 11'sd1);
        rnd_mag = {1'b0, rnd_e, 23'd0} + {7'd0, rnd_m25};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                F_IDLE: begin
                    if (i_start) begin
                        r_op    <= i_req.op;
                        r_a     <= i_req.opa;
                        r_b     <= i_req.opb;
                        r_state <= F_PREP;
                    end
                end
                F_PREP: begin
                    if (spc_hit) begin
                        r_value <= spc_val;
                        r_done  <= 1'b1;
                        r_state <= F_IDLE;
                    end else if (r_op == FOP_MUL) begin
                        r_sign  <= r_a[31] ^ r_b[31];
                        r_exp   <= $signed({3'd0, ea8}) + $signed({3'd0, eb8}) - 11'sd126;
                        r_sig   <= ma * mb;
                        r_state <= F_NORM;
                    end else begin
                        r_sub   <= r_a[31] ^ r_b[31];
                        r_sign  <= a_big ? r_a[31] : r_b[31];
                        r_exp   <= $signed({3'd0, a_big ? ea8 : eb8});
                        r_big   <= a_big ? ma : mb;
                        r_small <= a_big ? mb : ma;
                        r_d     <= a_big ? (ea8 - eb8) : (eb8 - ea8);
                        r_state <= F_ALIGN;
                    end
                end
                F_ALIGN: begin
                    if (sum49[48]) begin
                        r_sig <= sum49[48:1] | {47'd0, sum49[0]};
                        r_exp <= r_exp + 11'sd1;
                    end else begin
                        r_sig <= sum49[47:0];
                    end
                    r_state <= F_NORM;
                end
                F_NORM: begin
                    priority if (r_sig[47:40] == 8'd0) begin
                        r_sig <= r_sig << 8;
                        r_exp <= r_exp - 11'sd8;
                    end else if (!r_sig[47]) begin
                        r_sig <= r_sig << 1;
                        r_exp <= r_exp - 11'sd1;
                    end else if (r_exp >= 11'sd255) begin
                        r_value <= {r_sign, INF_MAG};
                        r_done  <= 1'b1;
                        r_state <= F_IDLE;
                    end else if (r_exp <= 11'sd0) begin
                        r_state <= F_DENORM;
                    end else begin
                        r_state <= F_ROUND;
                    end
                end
                F_DENORM: begin
                    // exponent field 0; a carry out of rounding lands in field 1
                    r_sig   <= dn_sig;
                    r_exp   <= 11'sd1;
                    r_state <= F_ROUND;
                end
                F_ROUND: begin
                    r_value <= {r_sign, rnd_mag[30:0]};
                    r_done  <= 1'b1;
                    r_state <= F_IDLE;
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = r_value;

endmodule

// File: sv/single_precision_matrix_multiply_core.sv
// Top level of the single precision matrix multiply core: command port, APB registers,
// row sequencer. Depends on smm_pkg, smm_store and smm_fpu.
//
// Usage:
//  - Configure rows_m (0x0), cols_n (0x4) and inner_k (0x8) over the APB port while idle.
//  - Command channel: a transaction is taken on a clock edge with start high and busy low.
//    cmd 0 writes A[row][col], cmd 1 writes B[row][col]; neither ever raises busy, so loads
//    stream at one per cycle while no row is being computed. cmd 3 does nothing.
//  - cmd 2 computes row `row` of C = A x B. busy rises for the whole row; the n elements
//    come out in column order, each for one cycle on o_item with o_res_valid, the last
//    one flagged. A row at or beyond rows_m, or cols_n zero, emits nothing.
//  - Each multiply-add step reads both stores, then runs one multiply and one add through
//    the shared FP unit. Special operands skip normalize and round; an add also aligns
//    its significands first, and a tiny significand takes extra normalize passes and a
//    shift into the subnormal range. A row runs inner_k such steps for each of its cols_n
//    elements.
//  - Results cannot be stalled: the receiver must take every strobe.
//  - Reset (synchronous, active low) clears the APB registers and the sequencer; store contents
//    are undefined until written.
module single_precision_matrix_multiply_core import smm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in_item    i_item,
    output logic        o_res_valid,
    output t_out_item   o_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_MWAIT = 3'd3;
    localparam logic [2:0] S_AWAIT = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    // configuration registers
    logic [DIM_W-1:0] r_rows_m, r_cols_n, r_inner_k;
    logic [DIM_W-1:0] m_sat, n_sat, k_sat;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_m  <= '0;
            r_cols_n  <= '0;
            r_inner_k <= '0;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_ROWS:  r_rows_m  <= pwdata[DIM_W-1:0];
                REG_COLS:  r_cols_n  <= pwdata[DIM_W-1:0];
                REG_INNER: r_inner_k <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_ROWS:  prdata = {25'd0, r_rows_m};
            REG_COLS:  prdata = {25'd0, r_cols_n};
            REG_INNER: prdata = {25'd0, r_inner_k};
            default:   prdata = 32'd0;
        endcase
    end

    // clamp oversized settings to the store dimensions
    assign m_sat = (r_rows_m  > ROWS_SAT)  ? ROWS_SAT  : r_rows_m;
    assign n_sat = (r_cols_n  > COLS_SAT)  ? COLS_SAT  : r_cols_n;
    assign k_sat = (r_inner_k > INNER_SAT) ? INNER_SAT : r_inner_k;

    // sequencer state
    logic [2:0]        r_state, n_state;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [DIM_W-1:0]  r_j, n_j;
    logic [DIM_W-1:0]  r_kk, n_kk;
    logic [WORD_W-1:0] r_acc, n_acc;
    logic              r_valid, n_valid;
    t_out_item         r_out, n_out;

    logic              accept;
    logic              row_ok;
    t_store_req        st_req;
    logic [WORD_W-1:0] rd_a, rd_b;
    logic              fpu_start;
    t_fpu_req          fpu_req;
    t_fpu_rsp          fpu_rsp;
    logic              elem_last;

    assign busy      = (r_state != S_IDLE);
    assign accept    = start && !busy;
    assign row_ok    = ({1'b0, i_item.row} < m_sat) && (n_sat != '0);
    assign elem_last = ((r_j + DIM_W'(1)) == n_sat);

    // store writes come straight from load transactions; reads follow the sequencer
    always_comb begin
        st_req.wr_a      = accept && (i_item.cmd == CMD_WR_A);
        st_req.wr_b      = accept && (i_item.cmd == CMD_WR_B);
        st_req.wr_addr_a = A_ADDR_W'(i_item.row * MAX_INNER + i_item.col);
        st_req.wr_addr_b = B_ADDR_W'(i_item.row * MAX_COLS + i_item.col);
        st_req.wr_data   = i_item.value;
        st_req.rd_addr_a = A_ADDR_W'(r_row * MAX_INNER + r_kk[ROW_W-1:0]);
        st_req.rd_addr_b = B_ADDR_W'(r_kk[ROW_W-1:0] * MAX_COLS + r_j[COL_W-1:0]);
    end

    smm_store u_store (
        .i_clk  (i_clk),
        .i_req  (st_req),
        .o_rd_a (rd_a),
        .o_rd_b (rd_b)
    );

    smm_fpu u_fpu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (fpu_start),
        .i_req   (fpu_req),
        .o_rsp   (fpu_rsp)
    );

    always_comb begin
        n_state   = r_state;
        n_row     = r_row;
        n_j       = r_j;
        n_kk      = r_kk;
        n_acc     = r_acc;
        n_valid   = 1'b0;
        n_out     = r_out;
        fpu_start = 1'b0;
        fpu_req   = '{op: FOP_MUL, opa: rd_a, opb: rd_b};
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_item.cmd == CMD_ROW) && row_ok) begin
                    n_row   = i_item.row;
                    n_j     = '0;
                    n_kk    = '0;
                    n_acc   = '0;
                    n_state = (k_sat == '0) ? S_EMIT : S_READ;
                end
            end
            S_READ: begin
                // addresses are on the store now; data lands next cycle
                n_state = S_MUL;
            end
            S_MUL: begin
                fpu_start = 1'b1;
                n_state   = S_MWAIT;
            end
            S_MWAIT: begin
                if (fpu_rsp.done) begin
                    fpu_start = 1'b1;
                    fpu_req   = '{op: FOP_ADD, opa: r_acc, opb: fpu_rsp.value};
                    n_state   = S_AWAIT;
                end
            end
            S_AWAIT: begin
                if (fpu_rsp.done) begin
                    n_acc   = fpu_rsp.value;
                    n_kk    = r_kk + DIM_W'(1);
                    n_state = (n_kk == k_sat) ? S_EMIT : S_READ;
                end
            end
            S_EMIT: begin
                n_valid         = 1'b1;
                n_out.out_row   = r_row;
                n_out.out_col   = r_j[COL_W-1:0];
                n_out.out_value = r_acc;
                n_out.last      = elem_last;
                n_j             = r_j + DIM_W'(1);
                n_kk            = '0;
                n_acc           = '0;
                if (elem_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = (k_sat == '0) ? S_EMIT : S_READ;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    // hold the datapath registers without reset
    always_ff @(posedge i_clk) begin
        r_row <= n_row;
        r_j   <= n_j;
        r_kk  <= n_kk;
        r_acc <= n_acc;
        r_out <= n_out;
    end

    assign o_res_valid = r_valid;
    assign o_item      = r_out;

    // the FP unit answers only while the sequencer waits for it
    a_fpu_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fpu_rsp.done |-> (r_state == S_MWAIT || r_state == S_AWAIT))
        else $error("FP unit result with no operation outstanding");

    // the final element of a row ends the row
    a_last_ends_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_item.last) |-> !busy)
        else $error("sequencer still busy after last element");

    // a row command that emits nothing leaves the block free
    a_empty_row_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_item.cmd == CMD_ROW) && !row_ok) |=> !busy)
        else $error("empty row command raised busy");

endmodule

// File: dv/smm_scoreboard.sv
`timescale 1ns / 100ps
// Scoreboard for the single precision matrix multiply core: tracks register writes and
// store loads, predicts each C row bit exactly and checks the result strobes. Uses smm_pkg.
module smm_scoreboard import smm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  t_in_item    i_item,
    input  logic        o_res_valid,
    input  t_out_item   o_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_errors,
    output int          o_pending
);

    logic [WORD_W-1:0] a_mem [A_DEPTH];
    logic [WORD_W-1:0] b_mem [B_DEPTH];
    logic [DIM_W-1:0]  rows_q, cols_q, inner_q;
    t_out_item         c_expected [$];

    function automatic bit fp_is_nan(logic [31:0] x);
        return x[30:0] > 31'h7F800000;
    endfunction

    function automatic bit fp_is_inf(logic [31:0] x);
        return x[30:0] == 31'h7F800000;
    endfunction

    function automatic bit fp_is_zero(logic [31:0] x);
        return x[30:0] == 31'h0;
    endfunction

    function automatic void fp_split(input logic [31:0] x, output int e,
                                     output logic [63:0] m);
        if (x[30:23] == 8'h0) begin
            e = 1;
            m = {41'h0, x[22:0]};
        end else begin
            e = int'(x[30:23]);
            m = {40'h0, 1'b1, x[22:0]};
        end
    endfunction

    // value is sig * 2^(e - 189); normalize, round to nearest even, pack
    function automatic logic [31:0] fp_round(logic s, int e, logic [63:0] sig);
        int          sh;
        logic [63:0] m;
        logic [63:0] rem;
        while (!sig[62]) begin
            sig = sig << 1;
            e--;
        end
        if (e >= 255) return {s, 8'hFF, 23'h0};
        if (e <= 0) begin
            sh = 1 - e;
            if (sh >= 63) sig = 64'd1;
            else sig = (sig >> sh) | 64'(|(sig & ((64'd1 << sh) - 64'd1)));
        end
        m   = sig >> 39;
        rem = {25'h0, sig[38:0]};
        if (rem > (64'd1 << 38) || (rem == (64'd1 << 38) && m[0])) m++;
        if (e <= 0) return {s, m[30:0]};
        return {s, 31'h0} + (32'(e - 1) << 23) + m[31:0];
    endfunction

    function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
        int          ea, eb;
        logic [63:0] ma, mb;
        logic        s;
        s = a[31] ^ b[31];
        if (fp_is_nan(a)) return a | 32'h400000;
        if (fp_is_nan(b)) return b | 32'h400000;
        if (fp_is_inf(a) || fp_is_inf(b)) begin
            if (fp_is_zero(a) || fp_is_zero(b)) return 32'h7FC00000;
            return {s, 31'h7F800000};
        end
        if (fp_is_zero(a) || fp_is_zero(b)) return {s, 31'h0};
        fp_split(a, ea, ma);
        fp_split(b, eb, mb);
        return fp_round(s, ea + eb - 111, ma * mb);
    endfunction

    function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
        int          ea, eb, e, d;
        logic [63:0] ma, mb, big, little;
        logic        sbig;
        if (fp_is_nan(a)) return a | 32'h400000;
        if (fp_is_nan(b)) return b | 32'h400000;
        if (fp_is_inf(a)) begin
            if (fp_is_inf(b) && a[31] != b[31]) return 32'h7FC00000;
            return a;
        end
        if (fp_is_inf(b)) return b;
        if (fp_is_zero(a) && fp_is_zero(b)) return {a[31] & b[31], 31'h0};
        if (fp_is_zero(a)) return b;
        if (fp_is_zero(b)) return a;
        fp_split(a, ea, ma);
        fp_split(b, eb, mb);
        ma = ma << 38;
        mb = mb << 38;
        if (ea > eb || (ea == eb && ma >= mb)) begin
            big = ma; little = mb; sbig = a[31]; e = ea; d = ea - eb;
        end else begin
            big = mb; little = ma; sbig = b[31]; e = eb; d = eb - ea;
        end
        if (d >= 63) little = 64'd1;
        else if (d > 0)
            little = (little >> d) | 64'(|(little & ((64'd1 << d) - 64'd1)));
        if (a[31] == b[31]) return fp_round(sbig, e + 1, big + little);
        if (big == little) return 32'h0;
        return fp_round(sbig, e + 1, big - little);
    endfunction

    function automatic int clamp_dim(logic [DIM_W-1:0] v);
        return (v > 7'd64) ? 64 : int'(v);
    endfunction

    // queue every element of C row r, accumulated in inner order
    function automatic void predict_row(int r);
        int          m, n, k;
        logic [31:0] acc;
        t_out_item   c;
        m = clamp_dim(rows_q);
        n = clamp_dim(cols_q);
        k = clamp_dim(inner_q);
        if (r >= m) return;
        for (int j = 0; j < n; j++) begin
            acc = 32'h0;
            for (int kk = 0; kk < k; kk++)
                acc = fp_add(acc, fp_mul(a_mem[r * MAX_INNER + kk], b_mem[kk * MAX_COLS + j]));
            c.out_row   = ROW_W'(r);
            c.out_col   = COL_W'(j);
            c.out_value = acc;
            c.last      = (j + 1 == n);
            c_expected.push_back(c);
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            rows_q   = '0;
            cols_q   = '0;
            inner_q  = '0;
            o_errors = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_ROWS:  rows_q  = pwdata[DIM_W-1:0];
                    REG_COLS:  cols_q  = pwdata[DIM_W-1:0];
                    REG_INNER: inner_q = pwdata[DIM_W-1:0];
                    default: ;
                endcase
            end
            if (start && !busy) begin
                case (i_item.cmd)
                    CMD_WR_A: a_mem[i_item.row * MAX_INNER + i_item.col] = i_item.value;
                    CMD_WR_B: b_mem[i_item.row * MAX_COLS + i_item.col] = i_item.value;
                    CMD_ROW:  predict_row(int'(i_item.row));
                    default: ;
                endcase
            end
            if (o_res_valid) begin
                if (c_expected.size() == 0) begin
                    $display("%0t: unexpected C element, actual %h", $time, o_item);
                    o_errors++;
                end else begin
                    want = c_expected.pop_front();
                    if (o_item !== want) begin
                        $display("%0t: C element mismatch, expected row %0d col %0d %h last %b,",
                                 $time, want.out_row, want.out_col, want.out_value, want.last);
                        $display("%0t:   actual row %0d col %0d %h last %b", $time,
                                 o_item.out_row, o_item.out_col, o_item.out_value, o_item.last);
                        o_errors++;
                    end
                end
            end
        end
        o_pending = c_expected.size();
    end

endmodule

// File: dv/single_precision_matrix_multiply_core_test.sv
`timescale 1ns / 100ps
// Top of the matrix multiply core testbench: clock, reset, APB setup and command traffic.
// Depends on smm_pkg, the core and smm_scoreboard, which does all checking.
module single_precision_matrix_multiply_core_test;
    import smm_pkg::*;

    // the unused command code: the core must swallow it silently
    localparam logic [1:0] CMD_NOP = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_in_item    i_item;
    logic        o_res_valid;
    t_out_item   o_item;
    logic        psel, penable, pwrite, pready;
    logic [3:0]  paddr;
    logic [31:0] pwdata, prdata;
    int          errors, pending;
    bit          gappy;

    single_precision_matrix_multiply_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_item(i_item),
        .o_res_valid(o_res_valid), .o_item(o_item), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    smm_scoreboard scoreboard (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_item(i_item),
        .o_res_valid(o_res_valid), .o_item(o_item), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .pready(pready),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Hard stop for a hung core: far beyond the slowest legal run.
    initial begin
        #100_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Mostly normal numbers near one so products stay finite, with a share of
    // special encodings and raw bit patterns to hit every exponent path.
    function automatic logic [31:0] pick_word();
        logic [31:0] specials [10] = '{32'h00000000, 32'h80000000, 32'h7F800000,
                                       32'hFF800000, 32'h7FC00000, 32'h7F800001,
                                       32'h00000001, 32'h807FFFFF, 32'h7F7FFFFF,
                                       32'h00800000};
        case ($urandom_range(0, 9))
            0: return specials[$urandom_range(0, 9)];
            1: return $urandom;
            default: return {1'($urandom), 8'($urandom_range(110, 140)), 23'($urandom)};
        endcase
    endfunction

    // Issue one command transaction and return at the edge that takes it. start stays
    // high afterward; the next idle gap or drain drops it.
    task automatic send(logic [1:0] cmd, int r, int c, logic [31:0] v);
        bit held;
        if (gappy) begin
            repeat ($urandom_range(0, 9)) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
        start        <= 1'b1;
        i_item.cmd   <= cmd;
        i_item.row   <= ROW_W'(r);
        i_item.col   <= COL_W'(c);
        i_item.value <= v;
        // busy only moves on a rising edge, so sample it mid cycle
        do begin
            @(negedge i_clk);
            held = busy;
            @(posedge i_clk);
        end while (held);
    endtask

    // Drop start, then wait for every expected element and for the sequencer to go quiet.
    task automatic drain();
        start <= 1'b0;
        do @(negedge i_clk); while (pending != 0 || busy);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [1:0] idx, int v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // One configuration phase: set all three dimensions, load the rows of A that
    // will be computed plus the used part of B, then mix loads, row requests and noise.
    task automatic run_phase(int m, int n, int k, int fill_rows, int count);
        int ms, ns, ks, pick, r;
        drain();
        apb_write(REG_ROWS, m);
        apb_write(REG_COLS, n);
        apb_write(REG_INNER, k);
        ms = (m > 64) ? 64 : m;
        ns = (n > 64) ? 64 : n;
        ks = (k > 64) ? 64 : k;
        gappy = 1'b1;
        for (int i = 0; i < fill_rows; i++)
            for (int j = 0; j < ks; j++) send(CMD_WR_A, i, j, pick_word());
        for (int i = 0; i < ks; i++)
            for (int j = 0; j < ns; j++) send(CMD_WR_B, i, j, pick_word());
        for (int t = 0; t < count; t++) begin
            // alternate stretches with and without idle cycles
            if (t % 20 == 0) gappy = ($urandom_range(0, 2) != 0);
            pick = $urandom_range(0, 9);
            if (pick <= 3) send(CMD_WR_A, $urandom_range(0, 63), $urandom_range(0, 63),
                                pick_word());
            else if (pick <= 5) send(CMD_WR_B, $urandom_range(0, 63), $urandom_range(0, 63),
                                     pick_word());
            else if (pick <= 8 && fill_rows > 0) send(CMD_ROW, $urandom_range(0, fill_rows - 1),
                                                      $urandom_range(0, 63), $urandom);
            else if (ms < 64 && $urandom_range(0, 1) == 1) begin
                r = $urandom_range(ms, 63);
                send(CMD_ROW, r, $urandom_range(0, 63), $urandom);
            end else send(CMD_NOP, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_item  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        gappy   = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: a 3x2 by 2x3 product built to hit inf*0, inf-inf, NaN
        // propagation and subnormal operands.
        apb_write(REG_ROWS, 3);
        apb_write(REG_COLS, 3);
        apb_write(REG_INNER, 2);
        send(CMD_WR_A, 0, 0, 32'h7F800000);
        send(CMD_WR_A, 0, 1, 32'h00000001);
        send(CMD_WR_A, 1, 0, 32'h7FA00000);
        send(CMD_WR_A, 1, 1, 32'h3FC00000);
        send(CMD_WR_A, 2, 0, 32'h7F7FFFFF);
        send(CMD_WR_A, 2, 1, 32'h7F7FFFFF);
        send(CMD_WR_B, 0, 0, 32'h00000000);
        send(CMD_WR_B, 0, 1, 32'h3F800000);
        send(CMD_WR_B, 0, 2, 32'hFF800000);
        send(CMD_WR_B, 1, 0, 32'h3F800000);
        send(CMD_WR_B, 1, 1, 32'h80000000);
        send(CMD_WR_B, 1, 2, 32'h7F800000);
        send(CMD_ROW, 0, 0, 32'h0);
        send(CMD_ROW, 1, 63, 32'hFFFFFFFF);
        send(CMD_ROW, 2, 0, 32'h0);
        // row beyond rows_m and the unused code must emit nothing
        send(CMD_ROW, 3, 0, 32'h0);
        send(CMD_ROW, 63, 63, 32'h0);
        send(CMD_NOP, 63, 63, 32'hFFFFFFFF);
        send(CMD_WR_A, 63, 63, 32'hFFFFFFFF);
        send(CMD_WR_B, 63, 63, 32'h00000000);
        send(CMD_WR_A, 0, 0, 32'h00000001);
        send(CMD_ROW, 0, 0, 32'h0);

        // Random phases; each one drains first, which also pauses the traffic
        // until every expected element is back.
        run_phase(0, 0, 0, 0, 8);
        run_phase(5, 3, 0, 5, 12);
        run_phase(2, 0, 3, 2, 10);
        run_phase(3, 4, 3, 3, 25);
        run_phase(127, 1, 127, 1, 5);
        run_phase(1, 127, 1, 1, 8);
        run_phase(1, 1, 1, 1, 15);
        drain();

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
